@@ sv/assert_macros.svh @@
// Assertion macros shared by the speed ramp RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while the synchronous reset is asserted.
`define ESR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define ESR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/esr_pkg.sv @@
// Types and constants of the encoder stepped speed ramp.
`default_nettype none

package esr_pkg;

    // Fixed field widths
    localparam int ENC_W       = 32;
    localparam int GOAL_W      = 31;
    localparam int DIST_W      = 16;
    localparam int STEP_W      = 16;
    localparam int SPEED_W     = 7;
    localparam int CMD_W       = 8;
    localparam int CNT_W       = 4;
    localparam int MULT_W      = 5;
    localparam int DP_W        = 33;
    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_DATA_W  = 16;

    // Input tdata bit positions
    localparam int TD_GOAL_LO  = 0;
    localparam int TD_DIST_LO  = 31;
    localparam int TD_REV      = 47;
    localparam int TD_INVA     = 48;
    localparam int TD_INVB     = 49;
    localparam int TD_ENCA_LO  = 50;
    localparam int TD_ENCB_LO  = 82;

    // Item kinds carried in tuser
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Register indexes
    localparam logic CFG_IDX_STEP  = 1'b0;
    localparam logic CFG_IDX_SPEED = 1'b1;

    // Register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd100;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 7'd5;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd127;

    // Distance thresholds in cm and the change counts they select
    localparam logic [DIST_W-1:0] DIST_TH8 = 16'd60;
    localparam logic [DIST_W-1:0] DIST_TH6 = 16'd45;
    localparam logic [DIST_W-1:0] DIST_TH4 = 16'd25;
    localparam logic [DIST_W-1:0] DIST_TH2 = 16'd15;
    localparam logic [CNT_W-1:0]  CHG_8    = 4'd8;
    localparam logic [CNT_W-1:0]  CHG_6    = 4'd6;
    localparam logic [CNT_W-1:0]  CHG_4    = 4'd4;
    localparam logic [CNT_W-1:0]  CHG_2    = 4'd2;
    localparam logic [CNT_W-1:0]  CHG_0    = 4'd0;

    localparam logic [MULT_W-1:0] MULT_START = 5'd2;
    localparam logic [MULT_W-1:0] MULT_STEP  = 5'd2;
    localparam logic [MULT_W-1:0] MULT_FLOOR = 5'd1;

    typedef struct packed {
        logic                     op;
        logic [GOAL_W-1:0]        target_pulses;
        logic [DIST_W-1:0]        distance_cm;
        logic                     reverse;
        logic                     invert_a;
        logic                     invert_b;
        logic signed [ENC_W-1:0]  encoder_a;
        logic signed [ENC_W-1:0]  encoder_b;
    } t_item;

    typedef struct packed {
        logic signed [CMD_W-1:0]  speed_command;
        logic                     move_done;
        logic                     busy_res;
    } t_result;

    typedef struct packed {
        logic [STEP_W-1:0]        step_pulses;
        logic [SPEED_W-1:0]       initial_speed;
    } t_cfg;

endpackage

`default_nettype wire

@@ sv/esr_enc_norm.sv @@
// Encoder count normalization: width select, sign extension and inversion.
`default_nettype none

module esr_enc_norm #(
    parameter int ENCODER_BITS = 32
) (
    input  wire logic signed [esr_pkg::ENC_W-1:0] i_raw,
    input  wire logic                             i_invert,
    output logic signed [esr_pkg::ENC_W-1:0]      o_value
);

    localparam int SHIFT = esr_pkg::ENC_W - ENCODER_BITS;

    logic [esr_pkg::ENC_W-1:0]        w_shl;
    logic signed [esr_pkg::ENC_W-1:0] w_ext;

    // Keep the low bits and sign-extend them by an arithmetic shift pair
    assign w_shl = i_raw << SHIFT;
    assign w_ext = $signed(w_shl) >>> SHIFT;

    // A nonzero inverted count becomes its complement
    assign o_value = (i_invert && (w_ext != '0)) ? ~w_ext : w_ext;

endmodule

`default_nettype wire

@@ sv/esr_ramp_core.sv @@
// Ramp state and single-pass speed update for one item.
`default_nettype none
`include "assert_macros.svh"

module esr_ramp_core #(
    parameter int ENCODER_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire esr_pkg::t_item  i_item,
    input  wire esr_pkg::t_cfg   i_cfg,
    output esr_pkg::t_result     o_result
);

    localparam int BND_W  = esr_pkg::STEP_W + esr_pkg::CNT_W;
    localparam int PROD_W = esr_pkg::SPEED_W + esr_pkg::MULT_W;
    localparam int CMP_W  = esr_pkg::DP_W + 1;

    // Move state
    logic                                r_active,  n_active;
    logic [esr_pkg::GOAL_W-1:0]          r_goal,    n_goal;
    logic [esr_pkg::CNT_W-1:0]           r_total,   n_total;
    logic [esr_pkg::CNT_W-1:0]           r_changes, n_changes;
    logic [esr_pkg::MULT_W-1:0]          r_accel,   n_accel;
    logic [esr_pkg::MULT_W-1:0]          r_decel,   n_decel;
    logic [esr_pkg::SPEED_W-1:0]         r_level,   n_level;
    logic signed [esr_pkg::DP_W-1:0]     r_dpoint,  n_dpoint;
    logic                                r_rev,     n_rev;
    logic                                r_inva,    n_inva;
    logic                                r_invb,    n_invb;

    logic signed [esr_pkg::ENC_W-1:0]    w_enc_a, w_enc_b;
    logic [esr_pkg::CNT_W-1:0]           w_start_total;
    logic [esr_pkg::CNT_W-1:0]           w_half;
    logic [BND_W-1:0]                    w_boundary;
    logic signed [CMP_W-1:0]             w_a_ext, w_b_ext, w_bnd_ext, w_dp_ext, w_goal_ext;
    logic                                w_acc_hit, w_dec_hit, w_finish;
    logic [esr_pkg::MULT_W-1:0]          w_dec_sub, w_dec_mult, w_mult;
    logic [PROD_W-1:0]                   w_prod;
    logic [esr_pkg::SPEED_W-1:0]         w_sat;
    logic [BND_W-1:0]                    w_start_off;
    logic [esr_pkg::SPEED_W-1:0]         w_out_mag;
    logic                                w_out_neg;

    // Encoder counts under the stored invert flags of the move
    esr_enc_norm #(.ENCODER_BITS(ENCODER_BITS)) u_norm_a (
        .i_raw    (i_item.encoder_a),
        .i_invert (r_inva),
        .o_value  (w_enc_a)
    );

    esr_enc_norm #(.ENCODER_BITS(ENCODER_BITS)) u_norm_b (
        .i_raw    (i_item.encoder_b),
        .i_invert (r_invb),
        .o_value  (w_enc_b)
    );

    // Change count from the move distance
    always_comb begin
        if (i_item.distance_cm >= esr_pkg::DIST_TH8) begin
            w_start_total = esr_pkg::CHG_8;
        end else if (i_item.distance_cm >= esr_pkg::DIST_TH6) begin
            w_start_total = esr_pkg::CHG_6;
        end else if (i_item.distance_cm >= esr_pkg::DIST_TH4) begin
            w_start_total = esr_pkg::CHG_4;
        end else if (i_item.distance_cm >= esr_pkg::DIST_TH2) begin
            w_start_total = esr_pkg::CHG_2;
        end else begin
            w_start_total = esr_pkg::CHG_0;
        end
    end

    // Step boundary and compares, all at a common signed width
    assign w_half      = r_total >> 1;
    assign w_boundary  = i_cfg.step_pulses * (r_changes + esr_pkg::CNT_W'(1));
    assign w_a_ext     = CMP_W'(w_enc_a);
    assign w_b_ext     = CMP_W'(w_enc_b);
    assign w_bnd_ext   = $signed({{(CMP_W-BND_W){1'b0}}, w_boundary});
    assign w_dp_ext    = CMP_W'(r_dpoint);
    assign w_goal_ext  = $signed({{(CMP_W-esr_pkg::GOAL_W){1'b0}}, r_goal});

    assign w_acc_hit = (r_changes < w_half) && (w_a_ext >= w_bnd_ext);
    assign w_dec_hit = (r_changes >= w_half) && (r_changes < r_total) && (w_a_ext >= w_dp_ext);
    assign w_finish  = (w_a_ext >= w_goal_ext) && (w_b_ext >= w_goal_ext);

    // Deceleration multiplier steps down by two with a floor of one
    assign w_dec_sub  = (r_decel >= esr_pkg::MULT_STEP) ? (r_decel - esr_pkg::MULT_STEP) : '0;
    assign w_dec_mult = (w_dec_sub == '0) ? esr_pkg::MULT_FLOOR : w_dec_sub;
    assign w_mult     = w_acc_hit ? r_accel : w_dec_mult;

    // Saturated speed for the selected multiplier
    assign w_prod = i_cfg.initial_speed * w_mult;
    assign w_sat  = (w_prod > PROD_W'(esr_pkg::SPEED_MAX)) ? esr_pkg::SPEED_MAX
                                                           : w_prod[esr_pkg::SPEED_W-1:0];

    assign w_start_off = BND_W'(i_cfg.step_pulses * (w_start_total >> 1));

    // Next state and result for the item in the input register
    always_comb begin
        n_active  = r_active;
        n_goal    = r_goal;
        n_total   = r_total;
        n_changes = r_changes;
        n_accel   = r_accel;
        n_decel   = r_decel;
        n_level   = r_level;
        n_dpoint  = r_dpoint;
        n_rev     = r_rev;
        n_inva    = r_inva;
        n_invb    = r_invb;
        w_out_mag = '0;
        w_out_neg = 1'b0;
        o_result.move_done = 1'b0;
        o_result.busy_res  = 1'b0;
        if (i_item.op == esr_pkg::OP_START) begin
            n_active  = 1'b1;
            n_goal    = i_item.target_pulses;
            n_total   = w_start_total;
            n_changes = '0;
            n_accel   = esr_pkg::MULT_START;
            n_decel   = '0;
            n_level   = i_cfg.initial_speed;
            n_dpoint  = $signed({{(esr_pkg::DP_W-esr_pkg::GOAL_W){1'b0}}, i_item.target_pulses})
                      - $signed({{(esr_pkg::DP_W-BND_W){1'b0}}, w_start_off});
            n_rev     = i_item.reverse;
            n_inva    = i_item.invert_a;
            n_invb    = i_item.invert_b;
            w_out_mag = i_cfg.initial_speed;
            w_out_neg = i_item.reverse;
            o_result.busy_res = 1'b1;
        end else if (r_active) begin
            if (w_acc_hit) begin
                n_level   = w_sat;
                n_changes = r_changes + esr_pkg::CNT_W'(1);
                n_accel   = r_accel + esr_pkg::MULT_STEP;
                n_decel   = r_accel;
            end else if (w_dec_hit) begin
                n_decel   = w_dec_mult;
                n_level   = w_sat;
                n_changes = r_changes + esr_pkg::CNT_W'(1);
                n_dpoint  = r_dpoint + $signed({{(esr_pkg::DP_W-esr_pkg::STEP_W){1'b0}},
                                                i_cfg.step_pulses});
            end
            if (w_finish) begin
                n_active = 1'b0;
                o_result.move_done = 1'b1;
            end else begin
                w_out_mag = n_level;
                w_out_neg = r_rev;
                o_result.busy_res = 1'b1;
            end
        end
        // Signed command from magnitude and direction
        o_result.speed_command = w_out_neg ? -$signed({1'b0, w_out_mag})
                                           : $signed({1'b0, w_out_mag});
    end

    // State update on each transfer through the core
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_goal    <= '0;
            r_total   <= '0;
            r_changes <= '0;
            r_accel   <= esr_pkg::MULT_START;
            r_decel   <= '0;
            r_level   <= '0;
            r_dpoint  <= '0;
            r_rev     <= 1'b0;
            r_inva    <= 1'b0;
            r_invb    <= 1'b0;
        end else if (i_fire) begin
            r_active  <= n_active;
            r_goal    <= n_goal;
            r_total   <= n_total;
            r_changes <= n_changes;
            r_accel   <= n_accel;
            r_decel   <= n_decel;
            r_level   <= n_level;
            r_dpoint  <= n_dpoint;
            r_rev     <= n_rev;
            r_inva    <= n_inva;
            r_invb    <= n_invb;
        end
    end

    `ESR_ASSERT(a_changes_bounded, i_clk, i_rst_n, r_changes <= r_total,
                "speed changes exceed the planned count")
    `ESR_ASSERT(a_total_even, i_clk, i_rst_n,
                (r_total[0] == 1'b0) && (r_total <= esr_pkg::CHG_8),
                "planned change count is not 0, 2, 4, 6 or 8")

endmodule

`default_nettype wire

@@ sv/encoder_stepped_speed_ramp_unit.sv @@
// o_m_tvalid rises once an input item has passed the input register and then the result register.
// Throughput: one item per cycle while i_m_tready is high; input and output registers each hold one item.
// The whole update is a single pass through the core between those registers.
// Reset (i_rst_n low, synchronous): no move active, step_pulses 100,
// initial_speed 5, both stream registers empty.
`default_nettype none
`include "assert_macros.svh"

module encoder_stepped_speed_ramp_unit #(
    parameter int ENCODER_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // target_pulses[30:0], distance_cm[46:31], reverse[47], invert_a[48],
    // invert_b[49], encoder_a[81:50], encoder_b[113:82], zero fill[119:114]
    input  wire logic [esr_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // op[0]
    input  wire logic [0:0]                          i_s_tuser,
    // Result stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // speed_command[7:0], move_done[8], busy_res[9], zero fill[15:10]
    output logic [esr_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    // Configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_idx,
    input  wire logic [esr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic              r_in_valid;
    esr_pkg::t_item    r_in;
    esr_pkg::t_item    w_item;
    logic              r_out_valid;
    esr_pkg::t_result  r_out;
    esr_pkg::t_result  w_result;
    esr_pkg::t_cfg     r_cfg;
    logic              w_fire;

    // Unpack the input transfer
    always_comb begin
        w_item.op            = i_s_tuser[0];
        w_item.target_pulses = i_s_tdata[esr_pkg::TD_GOAL_LO +: esr_pkg::GOAL_W];
        w_item.distance_cm   = i_s_tdata[esr_pkg::TD_DIST_LO +: esr_pkg::DIST_W];
        w_item.reverse       = i_s_tdata[esr_pkg::TD_REV];
        w_item.invert_a      = i_s_tdata[esr_pkg::TD_INVA];
        w_item.invert_b      = i_s_tdata[esr_pkg::TD_INVB];
        w_item.encoder_a     = i_s_tdata[esr_pkg::TD_ENCA_LO +: esr_pkg::ENC_W];
        w_item.encoder_b     = i_s_tdata[esr_pkg::TD_ENCB_LO +: esr_pkg::ENC_W];
    end

    // Core processes the held item when the output register can take its result
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_pulses   <= esr_pkg::STEP_RESET;
            r_cfg.initial_speed <= esr_pkg::SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                esr_pkg::CFG_IDX_STEP: begin
                    r_cfg.step_pulses <= i_cfg_data[esr_pkg::STEP_W-1:0];
                end
                esr_pkg::CFG_IDX_SPEED: begin
                    r_cfg.initial_speed <= i_cfg_data[esr_pkg::SPEED_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= w_item;
        end
    end

    esr_ramp_core #(.ENCODER_BITS(ENCODER_BITS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(esr_pkg::OUT_TDATA_W - esr_pkg::CMD_W - 2){1'b0}},
                         r_out.busy_res, r_out.move_done, r_out.speed_command};

    `ESR_ASSERT(a_fire_fills_output, i_clk, i_rst_n, w_fire |=> r_out_valid,
                "processed item did not reach the result register")
    `ESR_ASSERT(a_done_is_stopped, i_clk, i_rst_n,
                (r_out_valid && r_out.move_done) |-> ((r_out.speed_command == '0) && !r_out.busy_res),
                "finishing result carries a nonzero command or busy")

endmodule

`default_nettype wire
